[hdl/banker_safety_check_top_assert.svh]
// ----------------------------------------------------------------------------
// banker safety check assertion macros
// shared property forms, sampled on clock and held off during reset
// ----------------------------------------------------------------------------
`ifndef BANKER_SAFETY_CHECK_TOP_ASSERT_SVH
`define BANKER_SAFETY_CHECK_TOP_ASSERT_SVH

// consequent must hold in the same cycle as the antecedent
`define BSC_ASSERT_NOW(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("banker safety check assertion failed");

// consequent must hold in the cycle after the antecedent
`define BSC_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("banker safety check assertion failed");

`endif

[hdl/bsc_pkg.sv]
// ----------------------------------------------------------------------------
// bsc_pkg
// request codes, csr indexes, microcode steps, control word layout and the
// program of the safety check
// ----------------------------------------------------------------------------
package bsc_pkg;

   typedef enum logic [1:0] {
      OP_LOAD_TOTAL,
      OP_LOAD_ALLOC,
      OP_CHECK,
      OP_NONE
   } op_type;

   localparam logic CSR_PROCESS_COUNT  = 1'b0;
   localparam logic CSR_RESOURCE_COUNT = 1'b1;

   typedef enum logic [3:0] {
      S_INIT,
      S_SUM_R,
      S_SUM_RD,
      S_SUM_ACC,
      S_SUM_WR,
      S_SWEEP,
      S_PROC,
      S_PROC_DONE,
      S_FIT_RD,
      S_FIT_CMP,
      S_TAKE,
      S_ADD_RD,
      S_ADD,
      S_NEXT_P,
      S_SWEEP_END,
      S_FINISH
   } step_type;

   typedef enum logic [2:0] {
      C_NEVER,
      C_R_END,
      C_P_END,
      C_DONE,
      C_MISFIT,
      C_PROGRESS
   } cond_type;

   typedef struct packed {
      cond_type cond;
      step_type t_next;
      step_type f_next;
      logic     init;
      logic     acc_load;
      logic     acc_sub;
      logic     work_from_acc;
      logic     work_add;
      logic     r_clear;
      logic     r_inc;
      logic     p_clear;
      logic     p_inc;
      logic     progress_clear;
      logic     take;
      logic     finish;
   } ctrl_type;

   typedef struct packed {
      logic r_end;
      logic p_end;
      logic done;
      logic misfit;
      logic progress;
   } flags_type;

   // control store: cond true goes to t_next, otherwise to f_next
   function automatic ctrl_type ucode(input step_type s);
      ctrl_type w;
      w = '0;
      case (s)
         S_INIT: begin
            w.init    = 1'b1;
            w.r_clear = 1'b1;
            w.f_next  = S_SUM_R;
         end
         S_SUM_R: begin
            w.acc_load = 1'b1;
            w.p_clear  = 1'b1;
            w.cond     = C_R_END;
            w.t_next   = S_SWEEP;
            w.f_next   = S_SUM_RD;
         end
         S_SUM_RD: begin
            w.cond   = C_P_END;
            w.t_next = S_SUM_WR;
            w.f_next = S_SUM_ACC;
         end
         S_SUM_ACC: begin
            w.acc_sub = 1'b1;
            w.p_inc   = 1'b1;
            w.f_next  = S_SUM_RD;
         end
         S_SUM_WR: begin
            w.work_from_acc = 1'b1;
            w.r_inc         = 1'b1;
            w.f_next        = S_SUM_R;
         end
         S_SWEEP: begin
            w.progress_clear = 1'b1;
            w.p_clear        = 1'b1;
            w.f_next         = S_PROC;
         end
         S_PROC: begin
            w.cond   = C_P_END;
            w.t_next = S_SWEEP_END;
            w.f_next = S_PROC_DONE;
         end
         S_PROC_DONE: begin
            w.r_clear = 1'b1;
            w.cond    = C_DONE;
            w.t_next  = S_NEXT_P;
            w.f_next  = S_FIT_RD;
         end
         S_FIT_RD: begin
            w.cond   = C_R_END;
            w.t_next = S_TAKE;
            w.f_next = S_FIT_CMP;
         end
         S_FIT_CMP: begin
            w.r_inc  = 1'b1;
            w.cond   = C_MISFIT;
            w.t_next = S_NEXT_P;
            w.f_next = S_FIT_RD;
         end
         S_TAKE: begin
            w.take    = 1'b1;
            w.r_clear = 1'b1;
            w.f_next  = S_ADD_RD;
         end
         S_ADD_RD: begin
            w.cond   = C_R_END;
            w.t_next = S_NEXT_P;
            w.f_next = S_ADD;
         end
         S_ADD: begin
            w.work_add = 1'b1;
            w.r_inc    = 1'b1;
            w.f_next   = S_ADD_RD;
         end
         S_NEXT_P: begin
            w.p_inc  = 1'b1;
            w.f_next = S_PROC;
         end
         S_SWEEP_END: begin
            w.cond   = C_PROGRESS;
            w.t_next = S_SWEEP;
            w.f_next = S_FINISH;
         end
         S_FINISH: begin
            w.finish = 1'b1;
         end
         default: begin
            w.finish = 1'b1;
         end
      endcase
      return w;
   endfunction

endpackage

[hdl/bsc_ram.sv]
// ----------------------------------------------------------------------------
// bsc_ram
// generic one-write one-read ram with registered read data
// ----------------------------------------------------------------------------
module bsc_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 128,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[hdl/bsc_seq.sv]
// ----------------------------------------------------------------------------
// bsc_seq
// step counter over the control store, with conditional branch selection
// ----------------------------------------------------------------------------
module bsc_seq (
   input  logic                clock,
   input  logic                reset,
   input  logic                start_check,
   input  bsc_pkg::flags_type  flags,
   output bsc_pkg::ctrl_type   ctrl,
   output logic                busy
);

   bsc_pkg::step_type upc_ff, upc_in;
   logic              busy_ff, busy_in;
   bsc_pkg::ctrl_type word_w;
   logic              cond_w;

   always_comb begin
      word_w = bsc_pkg::ucode(upc_ff);
      case (word_w.cond)
         bsc_pkg::C_NEVER:    cond_w = 1'b0;
         bsc_pkg::C_R_END:    cond_w = flags.r_end;
         bsc_pkg::C_P_END:    cond_w = flags.p_end;
         bsc_pkg::C_DONE:     cond_w = flags.done;
         bsc_pkg::C_MISFIT:   cond_w = flags.misfit;
         bsc_pkg::C_PROGRESS: cond_w = flags.progress;
         default:             cond_w = 1'b0;
      endcase

      upc_in  = upc_ff;
      busy_in = busy_ff;
      if (!busy_ff) begin
         if (start_check) begin
            busy_in = 1'b1;
            upc_in  = bsc_pkg::S_INIT;
         end
      end else if (word_w.finish) begin
         busy_in = 1'b0;
      end else begin
         upc_in = cond_w ? word_w.t_next : word_w.f_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         upc_ff  <= bsc_pkg::S_INIT;
      end else begin
         busy_ff <= busy_in;
         upc_ff  <= upc_in;
      end
   end

   assign ctrl = busy_ff ? word_w : '0;
   assign busy = busy_ff;

endmodule

[hdl/banker_safety_check_top.sv]
// ----------------------------------------------------------------------------
// banker_safety_check_top
// deadlock-avoidance safety check over stored allocation and need tables
// ----------------------------------------------------------------------------
// usage:
//   a request word is taken when start is high and busy is low. op 0 loads a
//   resource total, op 1 loads one allocation and claim (need = claim - alloc),
//   op 2 runs the check, op 3 does nothing. loads give no response; busy stays
//   low so loads may follow every cycle.
//   a check raises busy and steps a microcoded sequencer over the stores,
//   which sit in rams with one registered read port. it first sums the free
//   units of each resource (total minus every allocation), then sweeps the
//   processes: each one not yet done is tested against the free units, and
//   one that fits is marked done and gives its allocation back. sweeps repeat
//   while one of them finishes somebody; number of sweeps is data dependent.
//   each finished process goes out as one response word, one cycle wide on
//   rsp_strobe; a word is held back until the next finish, so the final one
//   carries rsp_last and rsp_is_safe. if nobody finishes one word with
//   rsp_has_process low is sent. busy drops with the last word.
//   the receiver cannot stall; words are never held off.
//   csr index 0 is process_count, index 1 is resource_count. the user must
//   make writes only while idle; the block does not enforce it. reset restores
//   the counts, clears totals and the done flags; the rams need no clearing pass.
// ----------------------------------------------------------------------------
`include "banker_safety_check_top_assert.svh"

module banker_safety_check_top #(
   parameter int MAX_PROCS = 16,
   parameter int MAX_RES   = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_op,
   input  logic [3:0]  req_process_index,
   input  logic [2:0]  req_resource_index,
   input  logic [15:0] req_amount_a,
   input  logic [15:0] req_amount_b,
   output logic        rsp_strobe,
   output logic [3:0]  rsp_finished_process,
   output logic        rsp_has_process,
   output logic        rsp_is_safe,
   output logic        rsp_last,
   input  logic        csr_write_enable,
   input  logic        csr_index,
   input  logic [4:0]  csr_write_data
);

   localparam int PW    = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
   localparam int PCW   = $clog2(MAX_PROCS + 1);
   localparam int RW    = (MAX_RES > 1) ? $clog2(MAX_RES) : 1;
   localparam int RCW   = $clog2(MAX_RES + 1);
   localparam int DEPTH = MAX_PROCS * MAX_RES;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   // configuration
   logic [4:0] proc_count_ff, proc_count_in;
   logic [3:0] res_count_ff, res_count_in;

   // datapath state
   logic        [15:0] total_ff [MAX_RES];
   logic        [15:0] total_in [MAX_RES];
   logic signed [23:0] work_ff  [MAX_RES];
   logic signed [23:0] work_in  [MAX_RES];
   logic [MAX_PROCS-1:0] done_ff, done_in;
   logic signed [23:0] acc_ff, acc_in;
   logic [PCW-1:0]     p_ff, p_in;
   logic [RCW-1:0]     r_ff, r_in;
   logic               progress_ff, progress_in;
   logic [PCW-1:0]     fin_cnt_ff, fin_cnt_in;
   logic               pend_valid_ff, pend_valid_in;
   logic [3:0]         pend_proc_ff, pend_proc_in;

   // response registers
   logic       rsp_strobe_ff, rsp_strobe_in;
   logic [3:0] rsp_proc_ff, rsp_proc_in;
   logic       rsp_has_process_ff, rsp_has_process_in;
   logic       rsp_is_safe_ff, rsp_is_safe_in;
   logic       rsp_last_ff, rsp_last_in;

   logic               busy_w;
   logic               accept_w;
   logic               load_ok_w;
   logic               ram_we_w;
   logic [AW-1:0]      wr_addr_w;
   logic [AW-1:0]      rd_addr_w;
   logic [15:0]        alloc_rdata_w;
   logic [16:0]        need_wdata_w;
   logic [16:0]        need_rdata_w;
   logic [PCW-1:0]     np_w;
   logic [RCW-1:0]     nr_w;
   logic [PW-1:0]      p_idx_w;
   logic [RW-1:0]      r_idx_w;
   logic signed [23:0] work_r_w;
   logic signed [23:0] need_ext_w;
   logic signed [23:0] alloc_ext_w;
   bsc_pkg::ctrl_type  ctrl_w;
   bsc_pkg::flags_type flags_w;

   // counts above the store size are clamped
   assign np_w = ({3'b0, proc_count_ff} > 8'(MAX_PROCS)) ? PCW'(MAX_PROCS)
                                                         : PCW'(proc_count_ff);
   assign nr_w = ({4'b0, res_count_ff} > 8'(MAX_RES)) ? RCW'(MAX_RES)
                                                      : RCW'(res_count_ff);

   assign accept_w  = start && !busy_w;
   assign load_ok_w = (32'(req_process_index) < MAX_PROCS) &&
                      (32'(req_resource_index) < MAX_RES);
   assign ram_we_w  = accept_w && (req_op == bsc_pkg::OP_LOAD_ALLOC) && load_ok_w;
   assign wr_addr_w = AW'(int'(req_process_index) * MAX_RES + int'(req_resource_index));
   assign need_wdata_w = {1'b0, req_amount_b} - {1'b0, req_amount_a};

   assign p_idx_w   = p_ff[PW-1:0];
   assign r_idx_w   = r_ff[RW-1:0];
   assign rd_addr_w = AW'(int'(p_idx_w) * MAX_RES + int'(r_idx_w));

   assign work_r_w    = work_ff[r_idx_w];
   assign need_ext_w  = {{7{need_rdata_w[16]}}, need_rdata_w};
   assign alloc_ext_w = {8'b0, alloc_rdata_w};

   assign flags_w.r_end    = (r_ff == nr_w);
   assign flags_w.p_end    = (p_ff == np_w);
   assign flags_w.done     = done_ff[p_idx_w];
   assign flags_w.misfit   = (need_ext_w > work_r_w);
   assign flags_w.progress = progress_ff;

   bsc_ram #(
      .WIDTH (16),
      .DEPTH (DEPTH)
   ) u_alloc_ram (
      .clock   (clock),
      .wr_en   (ram_we_w),
      .wr_addr (wr_addr_w),
      .wr_data (req_amount_a),
      .rd_addr (rd_addr_w),
      .rd_data (alloc_rdata_w)
   );

   bsc_ram #(
      .WIDTH (17),
      .DEPTH (DEPTH)
   ) u_need_ram (
      .clock   (clock),
      .wr_en   (ram_we_w),
      .wr_addr (wr_addr_w),
      .wr_data (need_wdata_w),
      .rd_addr (rd_addr_w),
      .rd_data (need_rdata_w)
   );

   bsc_seq u_seq (
      .clock       (clock),
      .reset       (reset),
      .start_check (accept_w && (req_op == bsc_pkg::OP_CHECK)),
      .flags       (flags_w),
      .ctrl        (ctrl_w),
      .busy        (busy_w)
   );

   always_comb begin
      proc_count_in      = proc_count_ff;
      res_count_in       = res_count_ff;
      total_in           = total_ff;
      work_in            = work_ff;
      done_in            = done_ff;
      acc_in             = acc_ff;
      p_in               = p_ff;
      r_in               = r_ff;
      progress_in        = progress_ff;
      fin_cnt_in         = fin_cnt_ff;
      pend_valid_in      = pend_valid_ff;
      pend_proc_in       = pend_proc_ff;
      rsp_strobe_in      = 1'b0;
      rsp_proc_in        = rsp_proc_ff;
      rsp_has_process_in = rsp_has_process_ff;
      rsp_is_safe_in     = rsp_is_safe_ff;
      rsp_last_in        = rsp_last_ff;

      if (csr_write_enable) begin
         case (csr_index)
            bsc_pkg::CSR_PROCESS_COUNT:  proc_count_in = csr_write_data;
            bsc_pkg::CSR_RESOURCE_COUNT: res_count_in  = csr_write_data[3:0];
            default:                     proc_count_in = proc_count_ff;
         endcase
      end

      if (accept_w && (req_op == bsc_pkg::OP_LOAD_TOTAL) &&
          (32'(req_resource_index) < MAX_RES)) begin
         total_in[RW'(req_resource_index)] = req_amount_a;
      end

      if (ctrl_w.init) begin
         done_in       = '0;
         fin_cnt_in    = '0;
         pend_valid_in = 1'b0;
      end
      if (ctrl_w.r_clear) begin
         r_in = '0;
      end
      if (ctrl_w.r_inc) begin
         r_in = r_ff + 1'b1;
      end
      if (ctrl_w.p_clear) begin
         p_in = '0;
      end
      if (ctrl_w.p_inc) begin
         p_in = p_ff + 1'b1;
      end
      if (ctrl_w.acc_load) begin
         acc_in = {8'b0, total_ff[r_idx_w]};
      end
      if (ctrl_w.acc_sub) begin
         acc_in = acc_ff - alloc_ext_w;
      end
      if (ctrl_w.work_from_acc) begin
         work_in[r_idx_w] = acc_ff;
      end
      if (ctrl_w.work_add) begin
         work_in[r_idx_w] = work_r_w + alloc_ext_w;
      end
      if (ctrl_w.progress_clear) begin
         progress_in = 1'b0;
      end

      // a finish pushes out the word held from the previous finish
      if (ctrl_w.take) begin
         progress_in      = 1'b1;
         done_in[p_idx_w] = 1'b1;
         fin_cnt_in       = fin_cnt_ff + 1'b1;
         pend_valid_in    = 1'b1;
         pend_proc_in     = 4'(p_ff);
         if (pend_valid_ff) begin
            rsp_strobe_in      = 1'b1;
            rsp_proc_in        = pend_proc_ff;
            rsp_has_process_in = 1'b1;
            rsp_is_safe_in     = 1'b0;
            rsp_last_in        = 1'b0;
         end
      end

      if (ctrl_w.finish) begin
         rsp_strobe_in      = 1'b1;
         rsp_proc_in        = pend_valid_ff ? pend_proc_ff : 4'd0;
         rsp_has_process_in = pend_valid_ff;
         rsp_is_safe_in     = (fin_cnt_ff == np_w);
         rsp_last_in        = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         proc_count_ff <= 5'd16;
         res_count_ff  <= 4'd8;
         total_ff      <= '{default: '0};
         work_ff       <= '{default: '0};
         done_ff       <= '0;
         progress_ff   <= 1'b0;
         fin_cnt_ff    <= '0;
         pend_valid_ff <= 1'b0;
         p_ff          <= '0;
         r_ff          <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         proc_count_ff <= proc_count_in;
         res_count_ff  <= res_count_in;
         total_ff      <= total_in;
         work_ff       <= work_in;
         done_ff       <= done_in;
         progress_ff   <= progress_in;
         fin_cnt_ff    <= fin_cnt_in;
         pend_valid_ff <= pend_valid_in;
         p_ff          <= p_in;
         r_ff          <= r_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff             <= acc_in;
      pend_proc_ff       <= pend_proc_in;
      rsp_proc_ff        <= rsp_proc_in;
      rsp_has_process_ff <= rsp_has_process_in;
      rsp_is_safe_ff     <= rsp_is_safe_in;
      rsp_last_ff        <= rsp_last_in;
   end

   assign busy                 = busy_w;
   assign rsp_strobe           = rsp_strobe_ff;
   assign rsp_finished_process = rsp_proc_ff;
   assign rsp_has_process      = rsp_has_process_ff;
   assign rsp_is_safe          = rsp_is_safe_ff;
   assign rsp_last             = rsp_last_ff;

   `BSC_ASSERT_NOW(a_safe_only_on_last, rsp_strobe_ff && rsp_is_safe_ff, rsp_last_ff)
   `BSC_ASSERT_NOW(a_empty_only_on_last, rsp_strobe_ff && !rsp_has_process_ff, rsp_last_ff)
   `BSC_ASSERT_NOW(a_last_ends_check, rsp_strobe_ff && rsp_last_ff, !busy_w)
   `BSC_ASSERT_NEXT(a_held_word_goes_out, ctrl_w.take && pend_valid_ff, rsp_strobe_ff && rsp_has_process_ff && !rsp_last_ff)

endmodule

[tb/sv/tb_banker_safety_check_top.sv]
// ----------------------------------------------------------------------------
// tb_banker_safety_check_top
// self-checking bench for the banker safety check: loads totals, allocations
// and claims, runs checks over many count settings and compares every
// response word against a predicted safe sequence kept in a scoreboard
// ----------------------------------------------------------------------------
module tb_banker_safety_check_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int DRAIN_CYCLES = 8;
   localparam int TOTAL_WORDS  = 100;

   typedef struct packed {
      logic [3:0] proc;
      logic       has;
      logic       safe;
      logic       last;
   } finish_word_type;

   class safe_sequence_board;
      logic [4:0]         proc_count;
      logic [3:0]         res_count;
      logic [15:0]        total_units[8];
      logic [15:0]        alloc_units[16][8];
      logic signed [16:0] need_units[16][8];
      logic signed [23:0] work_units[8];
      bit                 done_flag[16];
      finish_word_type    pending_finishes[$];
      int                 errors;
      int                 n_checks;
      int                 n_words;
      int                 n_safe;

      function new();
         proc_count = 5'd16;
         res_count  = 4'd8;
         foreach (total_units[r]) total_units[r] = '0;
         foreach (work_units[r]) work_units[r] = '0;
         foreach (done_flag[p]) done_flag[p] = 1'b0;
         errors   = 0;
         n_checks = 0;
         n_words  = 0;
         n_safe   = 0;
      endfunction

      function void set_count(input logic idx, input logic [4:0] value);
         if (idx == bsc_pkg::CSR_PROCESS_COUNT)
            proc_count = value;
         else
            res_count = value[3:0];
      endfunction

      function int pending();
         return pending_finishes.size();
      endfunction

      function void predict_safe_sequence();
         int              np;
         int              nr;
         int              sum;
         int              finished;
         bit              progress;
         bit              fits;
         bit              safe;
         finish_word_type word;
         finish_word_type found[$];
         np = (proc_count > 16) ? 16 : int'(proc_count);
         nr = (res_count > 8) ? 8 : int'(res_count);
         for (int r = 0; r < nr; r++) begin
            sum = 0;
            for (int p = 0; p < np; p++) sum += int'(alloc_units[p][r]);
            work_units[r] = 24'(int'(total_units[r]) - sum);
         end
         foreach (done_flag[p]) done_flag[p] = 1'b0;
         finished = 0;
         progress = 1'b1;
         while (progress) begin
            progress = 1'b0;
            for (int p = 0; p < np; p++) begin
               if (!done_flag[p]) begin
                  fits = 1'b1;
                  for (int r = 0; r < nr; r++)
                     if (int'(need_units[p][r]) > int'(work_units[r])) fits = 1'b0;
                  if (fits) begin
                     for (int r = 0; r < nr; r++)
                        work_units[r] = 24'(int'(work_units[r]) + int'(alloc_units[p][r]));
                     done_flag[p] = 1'b1;
                     word.proc = 4'(p);
                     word.has  = 1'b1;
                     word.safe = 1'b0;
                     word.last = 1'b0;
                     found.push_back(word);
                     finished++;
                     progress = 1'b1;
                  end
               end
            end
         end
         safe = (finished == np);
         if (found.size() == 0) begin
            word.proc = 4'd0;
            word.has  = 1'b0;
            word.safe = safe;
            word.last = 1'b1;
            found.push_back(word);
         end else begin
            found[found.size() - 1].safe = safe;
            found[found.size() - 1].last = 1'b1;
         end
         foreach (found[i]) pending_finishes.push_back(found[i]);
         n_checks++;
         if (safe) n_safe++;
      endfunction

      function void note_request(input logic [1:0] op, input logic [3:0] pi,
                                 input logic [2:0] ri, input logic [15:0] a,
                                 input logic [15:0] b);
         case (op)
            bsc_pkg::OP_LOAD_TOTAL: begin
               total_units[ri] = a;
            end
            bsc_pkg::OP_LOAD_ALLOC: begin
               alloc_units[pi][ri] = a;
               need_units[pi][ri]  = 17'(int'(b) - int'(a));
            end
            bsc_pkg::OP_CHECK: begin
               predict_safe_sequence();
            end
            default: begin
            end
         endcase
      endfunction

      function void check_response(input logic [3:0] proc, input logic has,
                                   input logic safe, input logic last);
         finish_word_type want;
         n_words++;
         if (pending_finishes.size() == 0) begin
            errors++;
            $error("unexpected response word: finished_process %0d has_process %0d",
                   proc, has);
            return;
         end
         want = pending_finishes.pop_front();
         if (proc !== want.proc) begin
            errors++;
            $error("finished_process: expected %0d, actual %0d", want.proc, proc);
         end
         if (has !== want.has) begin
            errors++;
            $error("has_process: expected %0d, actual %0d", want.has, has);
         end
         if (safe !== want.safe) begin
            errors++;
            $error("is_safe: expected %0d, actual %0d", want.safe, safe);
         end
         if (last !== want.last) begin
            errors++;
            $error("last: expected %0d, actual %0d", want.last, last);
         end
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   logic [1:0]  req_op;
   logic [3:0]  req_process_index;
   logic [2:0]  req_resource_index;
   logic [15:0] req_amount_a;
   logic [15:0] req_amount_b;
   logic        rsp_strobe;
   logic [3:0]  rsp_finished_process;
   logic        rsp_has_process;
   logic        rsp_is_safe;
   logic        rsp_last;
   logic        csr_write_enable;
   logic        csr_index;
   logic [4:0]  csr_write_data;

   safe_sequence_board sb;
   bit                 no_gaps;
   int                 words_sent;

   banker_safety_check_top u_dut (
      .clock                (clock),
      .reset                (reset),
      .start                (start),
      .busy                 (busy),
      .req_op               (req_op),
      .req_process_index    (req_process_index),
      .req_resource_index   (req_resource_index),
      .req_amount_a         (req_amount_a),
      .req_amount_b         (req_amount_b),
      .rsp_strobe           (rsp_strobe),
      .rsp_finished_process (rsp_finished_process),
      .rsp_has_process      (rsp_has_process),
      .rsp_is_safe          (rsp_is_safe),
      .rsp_last             (rsp_last),
      .csr_write_enable     (csr_write_enable),
      .csr_index            (csr_index),
      .csr_write_data       (csr_write_data)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      #100ms;
      $display("tb_banker_safety_check_top: done, errors");
      $finish;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (start && !busy)
            sb.note_request(req_op, req_process_index, req_resource_index,
                            req_amount_a, req_amount_b);
         if (rsp_strobe)
            sb.check_response(rsp_finished_process, rsp_has_process, rsp_is_safe,
                              rsp_last);
      end
   end

   // called on a rising-edge step; returns on the step where the word was taken
   task automatic send_word(input bsc_pkg::op_type op, input logic [3:0] pi,
                            input logic [2:0] ri, input logic [15:0] a,
                            input logic [15:0] b);
      int gap;
      gap = no_gaps ? 0 : $urandom_range(0, 8);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start              <= 1'b1;
      req_op             <= op;
      req_process_index  <= pi;
      req_resource_index <= ri;
      req_amount_a       <= a;
      req_amount_b       <= b;
      do @(posedge clock); while (busy);
      words_sent++;
   endtask

   task automatic write_csr(input logic idx, input logic [4:0] value);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      sb.set_count(idx, value);
      @(posedge clock);
   endtask

   // wait out every expected word, then let the bench drain before touching csrs
   task automatic settle();
      start <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   function automatic logic [15:0] draw_amount();
      if ($urandom_range(0, 9) < 2)
         return 16'($urandom);
      return 16'($urandom_range(0, 6));
   endfunction

   // fresh tables over the active rows and columns, totals with some slack
   task automatic load_scenario(input int np, input int nr);
      int          sum[8];
      logic [15:0] a;
      foreach (sum[r]) sum[r] = 0;
      for (int p = 0; p < np; p++) begin
         for (int r = 0; r < nr; r++) begin
            a = 16'($urandom_range(0, 4));
            sum[r] += int'(a);
            send_word(bsc_pkg::OP_LOAD_ALLOC, 4'(p), 3'(r), a,
                      a + 16'($urandom_range(0, 4)));
         end
      end
      for (int r = 0; r < nr; r++)
         send_word(bsc_pkg::OP_LOAD_TOTAL, 4'($urandom), 3'(r),
                   16'(sum[r] + $urandom_range(0, 5)), 16'($urandom));
   endtask

   task automatic random_edit(input int np, input int nr);
      int          kind;
      logic [15:0] a;
      kind = $urandom_range(0, 9);
      if (kind < 3) begin
         send_word(bsc_pkg::OP_LOAD_ALLOC, 4'($urandom), 3'($urandom), draw_amount(),
                   draw_amount());
      end else if (kind < 6 && np > 0 && nr > 0) begin
         a = 16'($urandom_range(0, 4));
         send_word(bsc_pkg::OP_LOAD_ALLOC, 4'($urandom_range(0, np - 1)),
                   3'($urandom_range(0, nr - 1)), a, a + 16'($urandom_range(0, 3)));
      end else if (kind < 8) begin
         send_word(bsc_pkg::OP_LOAD_TOTAL, 4'($urandom), 3'($urandom), draw_amount(),
                   16'($urandom));
      end else begin
         send_word(bsc_pkg::OP_NONE, 4'($urandom), 3'($urandom), 16'($urandom),
                   16'($urandom));
      end
   endtask

   initial begin
      int         np;
      int         nr;
      int         phase;
      logic [4:0] pc;
      logic [4:0] rc;
      sb = new();
      no_gaps    = 1'b0;
      words_sent = 0;
      reset              <= 1'b1;
      start              <= 1'b0;
      req_op             <= bsc_pkg::OP_LOAD_TOTAL;
      req_process_index  <= '0;
      req_resource_index <= '0;
      req_amount_a       <= '0;
      req_amount_b       <= '0;
      csr_write_enable   <= 1'b0;
      csr_index          <= bsc_pkg::CSR_PROCESS_COUNT;
      csr_write_data     <= '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: two processes, two resources
      write_csr(bsc_pkg::CSR_PROCESS_COUNT, 5'd2);
      write_csr(bsc_pkg::CSR_RESOURCE_COUNT, 5'd2);
      send_word(bsc_pkg::OP_LOAD_TOTAL, 4'd0, 3'd0, 16'd3, 16'd0);
      send_word(bsc_pkg::OP_LOAD_TOTAL, 4'd0, 3'd1, 16'd3, 16'd0);
      send_word(bsc_pkg::OP_LOAD_ALLOC, 4'd0, 3'd0, 16'd1, 16'd3);
      send_word(bsc_pkg::OP_LOAD_ALLOC, 4'd0, 3'd1, 16'd0, 16'd2);
      send_word(bsc_pkg::OP_LOAD_ALLOC, 4'd1, 3'd0, 16'd1, 16'd2);
      send_word(bsc_pkg::OP_LOAD_ALLOC, 4'd1, 3'd1, 16'd2, 16'd2);
      send_word(bsc_pkg::OP_NONE, 4'hf, 3'h7, 16'hffff, 16'hffff);
      send_word(bsc_pkg::OP_CHECK, 4'd0, 3'd0, 16'd0, 16'd0);
      // rows outside the active range at the top indices
      send_word(bsc_pkg::OP_LOAD_ALLOC, 4'd15, 3'd7, 16'hffff, 16'd0);
      send_word(bsc_pkg::OP_LOAD_ALLOC, 4'd15, 3'd7, 16'd0, 16'hffff);
      send_word(bsc_pkg::OP_LOAD_TOTAL, 4'hf, 3'd7, 16'hffff, 16'hffff);
      // huge claim blocks everybody
      send_word(bsc_pkg::OP_LOAD_ALLOC, 4'd1, 3'd1, 16'd0, 16'hffff);
      send_word(bsc_pkg::OP_CHECK, 4'hf, 3'h7, 16'hffff, 16'hffff);
      // total below summed allocations: negative free units
      send_word(bsc_pkg::OP_LOAD_TOTAL, 4'd0, 3'd0, 16'd0, 16'd0);
      send_word(bsc_pkg::OP_CHECK, 4'd0, 3'd0, 16'd0, 16'd0);
      // claim below allocation gives a negative need
      send_word(bsc_pkg::OP_LOAD_ALLOC, 4'd0, 3'd0, 16'd5, 16'd0);
      send_word(bsc_pkg::OP_LOAD_ALLOC, 4'd0, 3'd1, 16'd0, 16'd0);
      send_word(bsc_pkg::OP_LOAD_TOTAL, 4'd0, 3'd0, 16'd10, 16'd0);
      send_word(bsc_pkg::OP_CHECK, 4'd0, 3'd0, 16'd0, 16'd0);
      settle();
      // no processes at all
      write_csr(bsc_pkg::CSR_PROCESS_COUNT, 5'd0);
      send_word(bsc_pkg::OP_CHECK, 4'd0, 3'd0, 16'd0, 16'd0);
      settle();
      // no resources: everybody fits
      write_csr(bsc_pkg::CSR_PROCESS_COUNT, 5'd2);
      write_csr(bsc_pkg::CSR_RESOURCE_COUNT, 5'd0);
      send_word(bsc_pkg::OP_CHECK, 4'd0, 3'd0, 16'd0, 16'd0);
      settle();

      phase = 0;
      while (phase < 3 || words_sent < TOTAL_WORDS) begin
         case (phase)
            0: begin
               pc = 5'd16;
               rc = 5'd2;
            end
            1: begin
               pc = 5'd31;
               rc = 5'd2;
            end
            2: begin
               pc = 5'd1;
               rc = 5'd15;
            end
            default: begin
               pc = 5'($urandom_range(1, 6));
               rc = 5'($urandom_range(1, 4));
            end
         endcase
         no_gaps = ($urandom_range(0, 3) == 0);
         write_csr(bsc_pkg::CSR_PROCESS_COUNT, pc);
         write_csr(bsc_pkg::CSR_RESOURCE_COUNT, rc);
         np = (pc > 16) ? 16 : int'(pc);
         nr = (rc > 8) ? 8 : int'(rc[3:0]);
         // all rows of the first two columns are loaded by the first phase
         if (phase != 1) load_scenario(np, nr);
         repeat ($urandom_range(2, 4)) begin
            repeat ($urandom_range(0, 3)) begin
               random_edit(np, nr);
            end
            send_word(bsc_pkg::OP_CHECK, 4'($urandom), 3'($urandom), 16'($urandom),
                      16'($urandom));
         end
         settle();
         phase++;
      end

      $display("summary: %0d request words, %0d checks over %0d count settings",
               words_sent, sb.n_checks, phase + 3);
      $display("summary: %0d response words, %0d checks came out safe",
               sb.n_words, sb.n_safe);
      if (sb.errors == 0)
         $display("tb_banker_safety_check_top: done, clean");
      else
         $display("tb_banker_safety_check_top: done, errors");
      $finish;
   end

endmodule
